// File: sv/sit_pkg.sv
// Package for the segment intersection test core.
// Holds the relation code type and its named codes; depends on nothing.
package sit_pkg;

    typedef logic [1:0] t_rel;

    localparam t_rel REL_SEPARATE  = 2'd0;
    localparam t_rel REL_INTERSECT = 2'd1;
    localparam t_rel REL_TOUCH     = 2'd2;
    localparam t_rel REL_UNUSED    = 2'd3;

endpackage

// File: sv/sit_if.sv
// Channel interfaces of the segment intersection test core.
// The pair channel carries eight coordinates, the result channel one relation code.
// Depends on sit_pkg.
interface sit_pair_if #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_end_x;
    logic signed [COORD_BITS-1:0] a_end_y;
    logic signed [COORD_BITS-1:0] b_start_x;
    logic signed [COORD_BITS-1:0] b_start_y;
    logic signed [COORD_BITS-1:0] b_end_x;
    logic signed [COORD_BITS-1:0] b_end_y;

    modport source (
        output valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        output ready
    );
endinterface

interface sit_rel_if import sit_pkg::*; ();
    logic valid;
    logic ready;
    t_rel relation;

    modport source (output valid, relation, input ready);
    modport sink (input valid, relation, output ready);
endinterface

// File: sv/sit_cross.sv
// Cross product terms of one orientation test (p, q, r).
// Produces (r.y-p.y)*(q.x-p.x) and (r.x-p.x)*(q.y-p.y) exactly; no package use.
module sit_cross #(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0]   i_px,
    input  logic signed [COORD_BITS-1:0]   i_py,
    input  logic signed [COORD_BITS-1:0]   i_qx,
    input  logic signed [COORD_BITS-1:0]   i_qy,
    input  logic signed [COORD_BITS-1:0]   i_rx,
    input  logic signed [COORD_BITS-1:0]   i_ry,
    output logic signed [2*COORD_BITS+1:0] o_s,
    output logic signed [2*COORD_BITS+1:0] o_t
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;

    logic signed [DW-1:0] dqx;
    logic signed [DW-1:0] dqy;
    logic signed [DW-1:0] drx;
    logic signed [DW-1:0] dry;
    logic signed [PW-1:0] ext_dqx;
    logic signed [PW-1:0] ext_dqy;
    logic signed [PW-1:0] ext_drx;
    logic signed [PW-1:0] ext_dry;

    assign dqx = DW'(i_qx) - DW'(i_px);
    assign dqy = DW'(i_qy) - DW'(i_py);
    assign drx = DW'(i_rx) - DW'(i_px);
    assign dry = DW'(i_ry) - DW'(i_py);

    assign ext_dqx = PW'(dqx);
    assign ext_dqy = PW'(dqy);
    assign ext_drx = PW'(drx);
    assign ext_dry = PW'(dry);

    assign o_s = ext_dry * ext_dqx;
    assign o_t = ext_drx * ext_dqy;
endmodule

// File: sv/segment_intersection_test_core.sv
// Top level of the segment intersection test core: input register, product stage and result.
// Depends on sit_pkg, sit_if.sv (sit_pair_if, sit_rel_if) and sit_cross.
//
//   Channel   Dir   Word
//   i_pair    in    two segments, eight signed coordinates
//   o_rel     out   relation code: separate, proper intersection or touching
//
// One pair is taken every cycle while the result channel keeps up; a result is offered from the relation stage.
// The input register loads on the taking edge, then the cross product and relation stages follow.
// Reset clears the stage valid flags only.
// Each stage holds while the stage after it is full and stalled, and empty stages fill,
// so a new pair can be taken while a finished result waits, as long as an earlier stage is empty.
module segment_intersection_test_core import sit_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sit_pair_if.sink  i_pair,
    sit_rel_if.source o_rel
);
    localparam int W  = COORD_BITS;
    localparam int PW = 2 * COORD_BITS + 2;

    logic rdy1;
    logic rdy2;
    logic rdy3;

    logic r_v1;
    logic r_v2;
    logic r_v3;

    logic signed [W-1:0] r_p1x, r_p1y, r_p2x, r_p2y, r_p3x, r_p3y, r_p4x, r_p4y;

    logic signed [W-1:0] t1x, t1y, t2x, t2y, t3x, t3y, t4x, t4y;
    logic signed [W-1:0] max12x, min12x, max12y, min12y;
    logic signed [W-1:0] max34x, min34x, max34y, min34y;
    logic                n_sep;
    logic signed [PW-1:0] n_s [4];
    logic signed [PW-1:0] n_t [4];

    logic                 r_sep;
    logic signed [W-1:0]  r_t1x, r_t1y, r_t2x, r_t2y, r_t3x, r_t3y, r_t4x, r_t4y;
    logic signed [PW-1:0] r_s [4];
    logic signed [PW-1:0] r_t [4];

    logic [3:0] c_pos;
    logic [3:0] c_neg;
    logic [3:0] c_zero;
    logic signed [W-1:0] t2ny, t6y, t7y, t8y;
    t_rel n_rel;
    t_rel r_rel;

    assign rdy3 = !r_v3 || o_rel.ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign i_pair.ready = rdy1;
    assign o_rel.valid    = r_v3;
    assign o_rel.relation = r_rel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_pair.valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pair.valid && rdy1) begin
            r_p1x <= i_pair.a_start_x;
            r_p1y <= i_pair.a_start_y;
            r_p2x <= i_pair.a_end_x;
            r_p2y <= i_pair.a_end_y;
            r_p3x <= i_pair.b_start_x;
            r_p3y <= i_pair.b_start_y;
            r_p4x <= i_pair.b_end_x;
            r_p4y <= i_pair.b_end_y;
        end
    end

    // Bounding boxes and endpoint order. The second segment is swapped on the end of A.
    always_comb begin
        max12x = (r_p1x > r_p2x) ? r_p1x : r_p2x;
        min12x = (r_p1x < r_p2x) ? r_p1x : r_p2x;
        max12y = (r_p1y > r_p2y) ? r_p1y : r_p2y;
        min12y = (r_p1y < r_p2y) ? r_p1y : r_p2y;
        max34x = (r_p3x > r_p4x) ? r_p3x : r_p4x;
        min34x = (r_p3x < r_p4x) ? r_p3x : r_p4x;
        max34y = (r_p3y > r_p4y) ? r_p3y : r_p4y;
        min34y = (r_p3y < r_p4y) ? r_p3y : r_p4y;
        n_sep  = (max34y < min12y) || (max12y < min34y) ||
                 (max34x < min12x) || (max12x < min34x);
        if (r_p2x >= r_p1x) begin
            t1x = r_p1x; t1y = r_p1y; t2x = r_p2x; t2y = r_p2y;
        end else begin
            t1x = r_p2x; t1y = r_p2y; t2x = r_p1x; t2y = r_p1y;
        end
        if (r_p2x >= r_p3x) begin
            t3x = r_p3x; t3y = r_p3y; t4x = r_p4x; t4y = r_p4y;
        end else begin
            t3x = r_p4x; t3y = r_p4y; t4x = r_p3x; t4y = r_p3y;
        end
    end

    sit_cross #(.COORD_BITS(COORD_BITS)) u_cross_123 (
        .i_px(t1x), .i_py(t1y), .i_qx(t2x), .i_qy(t2y), .i_rx(t3x), .i_ry(t3y),
        .o_s(n_s[0]), .o_t(n_t[0])
    );
    sit_cross #(.COORD_BITS(COORD_BITS)) u_cross_124 (
        .i_px(t1x), .i_py(t1y), .i_qx(t2x), .i_qy(t2y), .i_rx(t4x), .i_ry(t4y),
        .o_s(n_s[1]), .o_t(n_t[1])
    );
    sit_cross #(.COORD_BITS(COORD_BITS)) u_cross_341 (
        .i_px(t3x), .i_py(t3y), .i_qx(t4x), .i_qy(t4y), .i_rx(t1x), .i_ry(t1y),
        .o_s(n_s[2]), .o_t(n_t[2])
    );
    sit_cross #(.COORD_BITS(COORD_BITS)) u_cross_342 (
        .i_px(t3x), .i_py(t3y), .i_qx(t4x), .i_qy(t4y), .i_rx(t2x), .i_ry(t2y),
        .o_s(n_s[3]), .o_t(n_t[3])
    );

    always_ff @(posedge i_clk) begin
        if (r_v1 && rdy2) begin
            r_sep <= n_sep;
            r_t1x <= t1x; r_t1y <= t1y; r_t2x <= t2x; r_t2y <= t2y;
            r_t3x <= t3x; r_t3y <= t3y; r_t4x <= t4x; r_t4y <= t4y;
            for (int i = 0; i < 4; i++) begin
                r_s[i] <= n_s[i];
                r_t[i] <= n_t[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            c_pos[i]  = r_s[i] > r_t[i];
            c_neg[i]  = r_s[i] < r_t[i];
            c_zero[i] = !c_pos[i] && !c_neg[i];
        end
    end

    // Decision tree. Index 0..3 are the orientations 123, 124, 341 and 342.
    always_comb begin
        if (r_t2y >= r_t1y) begin
            t6y  = r_t1y;
            t2ny = r_t2y;
        end else begin
            t6y  = r_t2y;
            t2ny = r_t1y;
        end
        if (r_t3y >= r_t4y) begin
            t7y = r_t3y;
            t8y = r_t4y;
        end else begin
            t7y = r_t4y;
            t8y = r_t3y;
        end

        n_rel = REL_SEPARATE;
        if (r_sep) begin
            n_rel = REL_SEPARATE;
        end else if (((c_pos[0] && c_neg[1]) || (c_neg[0] && c_pos[1])) &&
                     ((c_pos[2] && c_neg[3]) || (c_neg[2] && c_pos[3]))) begin
            n_rel = REL_INTERSECT;
        end else if (c_zero[0] && c_zero[1]) begin
            n_rel = (r_t2x < r_t4x || r_t3x < r_t1x) ? REL_SEPARATE : REL_TOUCH;
        end else if (!c_zero[0] && !c_zero[1] && !c_zero[2] && !c_zero[3]) begin
            n_rel = REL_SEPARATE;
        end else if (!c_zero[0]) begin
            if (r_t3x < r_t1x || r_t2x < r_t3x) begin
                n_rel = REL_SEPARATE;
            end else if (r_t1x != r_t3x || r_t2x != r_t1x) begin
                n_rel = REL_TOUCH;
            end else if (r_t3y >= t6y && r_t3y <= t2ny) begin
                n_rel = REL_TOUCH;
            end else begin
                n_rel = REL_SEPARATE;
            end
        end else if (!c_zero[1]) begin
            if (!c_zero[2]) begin
                if (!c_zero[3] || r_t2x < r_t3x || r_t4x < r_t2x) begin
                    n_rel = REL_SEPARATE;
                end else if (r_t3x != r_t2x || r_t4x != r_t3x) begin
                    n_rel = REL_TOUCH;
                end else if (r_t2y < t7y) begin
                    n_rel = REL_SEPARATE;
                end else begin
                    n_rel = (r_t2y <= t8y) ? REL_TOUCH : REL_SEPARATE;
                end
            end else begin
                if (r_t1x < r_t3x || r_t4x < r_t1x) begin
                    n_rel = REL_SEPARATE;
                end else if (r_t3x != r_t1x || r_t4x != r_t3x) begin
                    n_rel = REL_TOUCH;
                end else if (r_t1y < t7y) begin
                    n_rel = REL_SEPARATE;
                end else begin
                    n_rel = (r_t1y <= t8y) ? REL_TOUCH : REL_SEPARATE;
                end
            end
        end else begin
            if (r_t4x < r_t1x || r_t2x < r_t4x) begin
                n_rel = REL_SEPARATE;
            end else if (r_t1x != r_t4x || r_t2x != r_t1x) begin
                n_rel = REL_TOUCH;
            end else if (r_t4y < t6y) begin
                n_rel = REL_SEPARATE;
            end else begin
                n_rel = (r_t4y <= t2ny) ? REL_TOUCH : REL_SEPARATE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && rdy3) begin
            r_rel <= n_rel;
        end
    end

`ifndef SYNTHESIS
    a_no_unused_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rel.valid |-> (o_rel.relation != REL_UNUSED))
        else $error("relation carries the unused code");

    a_box_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && rdy3 && r_sep) |=> (r_rel == REL_SEPARATE))
        else $error("bounding box reject did not give separate");

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pair.valid && i_pair.ready) |=> r_v1)
        else $error("accepted pair not held in the input stage");
`endif
endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Testbench for segment_intersection_test_core: directed and random segment pairs
// with random idling on both channels, checked against an in-bench classifier.
// Depends on sit_pkg and the channel interfaces in sit_if.sv.

import sit_pkg::*;

typedef logic signed [15:0] coord_t;

typedef struct packed {
    coord_t asx;
    coord_t asy;
    coord_t aex;
    coord_t aey;
    coord_t bsx;
    coord_t bsy;
    coord_t bex;
    coord_t bey;
} seg_pair_t;

typedef struct {
    longint x;
    longint y;
} pt_t;

class relation_ledger;
    t_rel        pending_rel[$];
    seg_pair_t   pending_pair[$];
    int unsigned n_fail;
    int unsigned n_pairs;
    int unsigned rel_seen[4];

    function longint lmax(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    function longint lmin(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    // Sign of the cross product: +1 counter-clockwise, -1 clockwise, 0 collinear.
    function int orient(pt_t p, pt_t q, pt_t r);
        longint lhs;
        longint rhs;
        lhs = (r.y - p.y) * (q.x - p.x);
        rhs = (r.x - p.x) * (q.y - p.y);
        if (lhs > rhs) return 1;
        if (lhs < rhs) return -1;
        return 0;
    endfunction

    function t_rel predict_relation(seg_pair_t s);
        pt_t    p1, p2, p3, p4, t1, t2, t3, t4;
        int     c123, c124, c341, c342;
        longint a_lo_y, a_hi_y, b_lo_y, b_hi_y, f1, f2;
        p1.x = $signed(s.asx); p1.y = $signed(s.asy);
        p2.x = $signed(s.aex); p2.y = $signed(s.aey);
        p3.x = $signed(s.bsx); p3.y = $signed(s.bsy);
        p4.x = $signed(s.bex); p4.y = $signed(s.bey);

        if (lmax(p3.y, p4.y) < lmin(p1.y, p2.y) || lmax(p1.y, p2.y) < lmin(p3.y, p4.y) ||
            lmax(p3.x, p4.x) < lmin(p1.x, p2.x) || lmax(p1.x, p2.x) < lmin(p3.x, p4.x))
            return REL_SEPARATE;

        if (p2.x >= p1.x) begin
            t1 = p1; t2 = p2;
        end else begin
            t1 = p2; t2 = p1;
        end
        // The second segment is ordered against the end of the first one.
        if (p2.x >= p3.x) begin
            t3 = p3; t4 = p4;
        end else begin
            t3 = p4; t4 = p3;
        end

        c123 = orient(t1, t2, t3);
        c124 = orient(t1, t2, t4);
        c341 = orient(t3, t4, t1);
        c342 = orient(t3, t4, t2);

        if (c123 * c124 < 0 && c341 * c342 < 0)
            return REL_INTERSECT;
        if (c123 == 0 && c124 == 0)
            return (t2.x < t4.x || t3.x < t1.x) ? REL_SEPARATE : REL_TOUCH;
        if (c123 != 0 && c124 != 0 && c341 != 0 && c342 != 0)
            return REL_SEPARATE;

        a_lo_y = lmin(t1.y, t2.y);
        a_hi_y = lmax(t1.y, t2.y);

        if (c123 != 0) begin
            if (t3.x < t1.x || t2.x < t3.x) return REL_SEPARATE;
            if (t1.x != t3.x || t2.x != t1.x) return REL_TOUCH;
            return (t3.y >= a_lo_y && t3.y <= a_hi_y) ? REL_TOUCH : REL_SEPARATE;
        end

        if (c124 != 0) begin
            b_hi_y = lmax(t3.y, t4.y);
            b_lo_y = lmin(t3.y, t4.y);
            if (c341 != 0) begin
                if (c342 != 0 || t2.x < t3.x || t4.x < t2.x) return REL_SEPARATE;
                if (t3.x != t2.x || t4.x != t3.x) return REL_TOUCH;
                if (t2.y < b_hi_y) return REL_SEPARATE;
                f1 = b_lo_y;
                f2 = t2.y;
            end else begin
                if (t1.x < t3.x || t4.x < t1.x) return REL_SEPARATE;
                if (t3.x != t1.x || t4.x != t3.x) return REL_TOUCH;
                if (t1.y < b_hi_y) return REL_SEPARATE;
                f1 = b_lo_y;
                f2 = t1.y;
            end
        end else begin
            if (t4.x < t1.x || t2.x < t4.x) return REL_SEPARATE;
            if (t1.x != t4.x || t2.x != t1.x) return REL_TOUCH;
            if (t4.y < a_lo_y) return REL_SEPARATE;
            f1 = a_hi_y;
            f2 = t4.y;
        end
        return (f2 <= f1) ? REL_TOUCH : REL_SEPARATE;
    endfunction

    function void note_pair(seg_pair_t s);
        t_rel r;
        r = predict_relation(s);
        pending_rel.push_back(r);
        pending_pair.push_back(s);
        rel_seen[r]++;
        n_pairs++;
    endfunction

    function void check_relation(t_rel got);
        t_rel      want;
        seg_pair_t s;
        if (pending_rel.size() == 0) begin
            n_fail++;
            if (n_fail <= 10)
                $display("Relation %0d arrived with no pair outstanding.", got);
            return;
        end
        want = pending_rel.pop_front();
        s = pending_pair.pop_front();
        if (got !== want) begin
            n_fail++;
            if (n_fail <= 10)
                $display("Bad relation for a (%0d,%0d)-(%0d,%0d) b (%0d,%0d)-(%0d,%0d): expected %0d, got %0d.",
                         s.asx, s.asy, s.aex, s.aey, s.bsx, s.bsy, s.bex, s.bey, want, got);
        end
    endfunction

    function int outstanding();
        return pending_rel.size();
    endfunction
endclass

module testbench;

    localparam int RANDOM_PAIRS = 1700;
    localparam int LONG_HOLD    = 300;
    localparam int CORNER_VALS[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

    logic i_clk;
    logic i_rst_n;
    bit   rst_done = 1'b0;
    bit   tx_calm = 1'b0;
    bit   rx_calm = 1'b0;
    int   rx_hold_left = 0;

    relation_ledger ledger;

    sit_pair_if #(.COORD_BITS(16)) pair_ch ();
    sit_rel_if                     rel_ch ();

    segment_intersection_test_core #(
        .COORD_BITS(16)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (pair_ch),
        .o_rel   (rel_ch)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    function automatic seg_pair_t pack_pair(int c0, int c1, int c2, int c3,
                                            int c4, int c5, int c6, int c7);
        seg_pair_t s;
        s.asx = coord_t'(c0); s.asy = coord_t'(c1);
        s.aex = coord_t'(c2); s.aey = coord_t'(c3);
        s.bsx = coord_t'(c4); s.bsy = coord_t'(c5);
        s.bex = coord_t'(c6); s.bey = coord_t'(c7);
        return s;
    endfunction

    function automatic int rand_span(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Mixes full-range noise with small grids, shared endpoints, collinear runs,
    // axis-aligned segments and corner values, so the deep branches are reached.
    function automatic seg_pair_t random_pair();
        int c[8];
        int bx, by, dx, dy, tmp, i;
        for (i = 0; i < 8; i++) c[i] = 0;
        case ($urandom_range(0, 9))
            0, 1: begin
                for (i = 0; i < 8; i++) c[i] = int'($urandom_range(0, 65535)) - 32768;
            end
            2, 3, 4: begin
                for (i = 0; i < 8; i++) c[i] = rand_span(4);
            end
            5: begin
                for (i = 0; i < 4; i++) c[i] = rand_span(1000);
                case ($urandom_range(0, 2))
                    0: begin
                        c[4] = c[0]; c[5] = c[1];
                    end
                    1: begin
                        c[4] = c[2]; c[5] = c[3];
                    end
                    default: begin
                        if ((c[0] + c[2]) % 2 == 0 && (c[1] + c[3]) % 2 == 0) begin
                            c[4] = (c[0] + c[2]) / 2; c[5] = (c[1] + c[3]) / 2;
                        end else begin
                            c[4] = c[0]; c[5] = c[1];
                        end
                    end
                endcase
                c[6] = rand_span(1000);
                c[7] = rand_span(1000);
                if ($urandom_range(0, 1) == 1) begin
                    tmp = c[4]; c[4] = c[6]; c[6] = tmp;
                    tmp = c[5]; c[5] = c[7]; c[7] = tmp;
                end
            end
            6: begin
                bx = rand_span(10000);
                by = rand_span(10000);
                dx = rand_span(20);
                dy = rand_span(20);
                for (i = 0; i < 4; i++) begin
                    tmp = $urandom_range(0, 10);
                    c[2 * i] = bx + tmp * dx;
                    c[2 * i + 1] = by + tmp * dy;
                end
            end
            7: begin
                for (i = 0; i < 8; i++) c[i] = rand_span(30);
                c[2] = c[0];
                if ($urandom_range(0, 1) == 1) begin
                    c[4] = c[0]; c[6] = c[0];
                end else begin
                    c[7] = c[5];
                end
            end
            8: begin
                for (i = 0; i < 8; i++) c[i] = CORNER_VALS[$urandom_range(0, 6)];
            end
            default: begin
                for (i = 0; i < 4; i++) c[i] = int'($urandom_range(0, 65535)) - 32768;
                c[4] = c[2]; c[5] = c[3];
                c[6] = int'($urandom_range(0, 65535)) - 32768;
                c[7] = int'($urandom_range(0, 65535)) - 32768;
            end
        endcase
        return pack_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endfunction

    task automatic send_pair(input seg_pair_t s);
        int gap;
        if ($urandom_range(0, 47) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            pair_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pair_ch.valid     <= 1'b1;
        pair_ch.a_start_x <= s.asx;
        pair_ch.a_start_y <= s.asy;
        pair_ch.a_end_x   <= s.aex;
        pair_ch.a_end_y   <= s.aey;
        pair_ch.b_start_x <= s.bsx;
        pair_ch.b_start_y <= s.bsy;
        pair_ch.b_end_x   <= s.bex;
        pair_ch.b_end_y   <= s.bey;
        do @(posedge i_clk); while (!pair_ch.ready);
        ledger.note_pair(s);
    endtask

    task automatic wait_for_results();
        pair_ch.valid <= 1'b0;
        do @(posedge i_clk); while (ledger.outstanding() != 0);
    endtask

    initial begin : result_sink
        int stall;
        rel_ch.ready <= 1'b0;
        while (!rst_done) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 47) == 0) rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 5);
            if (stall > 0 || rx_hold_left > 0) begin
                rel_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                while (rx_hold_left > 0) @(posedge i_clk);
            end
            rel_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rel_ch.valid);
            ledger.check_relation(rel_ch.relation);
        end
    end

    initial begin : stimulus
        int i;
        ledger = new();
        i_rst_n           <= 1'b0;
        pair_ch.valid     <= 1'b0;
        pair_ch.a_start_x <= '0;
        pair_ch.a_start_y <= '0;
        pair_ch.a_end_x   <= '0;
        pair_ch.a_end_y   <= '0;
        pair_ch.b_start_x <= '0;
        pair_ch.b_start_y <= '0;
        pair_ch.b_end_x   <= '0;
        pair_ch.b_end_y   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rst_done = 1'b1;

        send_pair(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(pack_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_pair(pack_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(pack_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(pack_pair(-32768, 32767, 32767, -32768, 0, 0, 32767, 32767));
        send_pair(pack_pair(0, 0, 10, 0, 20, 5, 30, 5));
        send_pair(pack_pair(0, 0, 10, 10, 5, 5, 20, 20));
        send_pair(pack_pair(0, 0, 5, 5, 5, 5, 9, 9));
        send_pair(pack_pair(10, 0, 0, 10, 0, 0, 10, 10));
        send_pair(pack_pair(0, 0, 10, 0, 5, 0, 5, 8));
        send_pair(pack_pair(0, 0, 10, 0, 10, 0, 15, 7));
        send_pair(pack_pair(3, 0, 3, 10, 3, 5, 3, 20));
        send_pair(pack_pair(3, 0, 3, 4, 3, 6, 3, 9));
        send_pair(pack_pair(3, -5, 3, 5, -5, 0, 5, 0));
        send_pair(pack_pair(2, 2, 2, 2, 0, 0, 4, 4));
        send_pair(pack_pair(1, 3, 1, 3, 0, 0, 4, 4));
        send_pair(pack_pair(0, 0, 8, 4, 4, 2, 4, 2));
        send_pair(pack_pair(7, -7, 7, -7, 7, -7, 7, -7));
        send_pair(pack_pair(0, 0, 4, 4, 6, 0, 2, 4));
        send_pair(pack_pair(0, 0, 4, 0, 6, 3, 4, 0));
        send_pair(pack_pair(0, 0, 0, 5, 0, 5, 0, 9));
        send_pair(pack_pair(5, 0, 5, 10, 5, 10, 0, 10));
        send_pair(pack_pair(0, 0, 10, 10, 0, 1, 9, 10));
        send_pair(pack_pair(0, 0, 0, 10, 0, 5, 7, 5));
        send_pair(pack_pair(0, 10, 0, 0, 0, 12, 0, 3));
        wait_for_results();

        for (i = 0; i < RANDOM_PAIRS; i++) begin
            if (i == 300) rx_hold_left <= LONG_HOLD;
            if (i == 900) wait_for_results();
            send_pair(random_pair());
        end
        wait_for_results();
        repeat (8) @(posedge i_clk);

        $display("Checked %0d segment pairs: %0d separate, %0d crossing, %0d touching.",
                 ledger.n_pairs, ledger.rel_seen[REL_SEPARATE], ledger.rel_seen[REL_INTERSECT],
                 ledger.rel_seen[REL_TOUCH]);
        $display("Stimulus covered corner coordinates, collinear, axis-aligned, degenerate and shared-endpoint pairs, with a %0d-cycle output hold.",
                 LONG_HOLD);
        if (ledger.n_fail == 0 && ledger.outstanding() == 0) begin
            $display("segment_intersection_test_core: match");
        end else begin
            $display("Failures: %0d, results still outstanding: %0d.",
                     ledger.n_fail, ledger.outstanding());
            $display("segment_intersection_test_core: mismatch");
        end
        $finish;
    end

    initial begin : run_limit
        #5000000;
        $display("Run timed out with %0d results outstanding.", ledger.outstanding());
        $display("segment_intersection_test_core: mismatch");
        $finish;
    end

endmodule

// File: files.f
sv/sit_pkg.sv
sv/sit_if.sv
sv/sit_cross.sv
sv/segment_intersection_test_core.sv
dv/testbench.sv
